// ===== rtl/dqe_pkg.sv =====
package dqe_pkg;

  // message layout
  localparam int unsigned HdrLen  = 12;
  localparam int unsigned MaxName = 255;
  localparam int unsigned MaxLabel = 63;
  localparam int unsigned TermResults = 6;

  localparam logic [7:0]  CharDot   = 8'h2E;
  localparam logic [7:0]  CharEnd   = 8'h00;
  localparam logic [15:0] QcountOne = 16'h0100;
  localparam logic [15:0] ClassIn   = 16'h0100;

  // what one name character turns into
  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_CHAR,
    KIND_PATCH,
    KIND_TERM,
    KIND_FAIL
  } dqe_kind_e;

  typedef struct packed {
    logic [7:0]  name_char;
    logic        first;
    logic [15:0] xid;
    logic [15:0] query_type;
    logic        recursion_desired;
  } dqe_item_t;

  // decoded item waiting for serialization
  typedef struct packed {
    logic        hdr;
    logic [15:0] xid;
    logic        rd;
    dqe_kind_e   kind;
    logic [8:0]  ofs;
    logic [7:0]  val;
    logic [8:0]  wofs;
    logic [15:0] qtype;
    logic [4:0]  cnt;
  } dqe_job_t;

  typedef struct packed {
    logic [8:0] byte_offset;
    logic [7:0] byte_value;
    logic       last;
    logic       status;
    logic [8:0] message_length;
  } dqe_result_t;

endpackage

// ===== rtl/dqe_if.sv =====
// name character channel
interface dqe_item_if;
  logic        valid;
  logic        ready;
  logic [7:0]  name_char;
  logic        first;
  logic [15:0] xid;
  logic [15:0] query_type;
  logic        recursion_desired;

  modport source (
    output valid, name_char, first, xid, query_type, recursion_desired,
    input  ready
  );
  modport sink (
    input  valid, name_char, first, xid, query_type, recursion_desired,
    output ready
  );
endinterface

// message byte channel
interface dqe_result_if;
  logic       valid;
  logic       ready;
  logic [8:0] byte_offset;
  logic [7:0] byte_value;
  logic       last;
  logic       status;
  logic [8:0] message_length;

  modport source (
    output valid, byte_offset, byte_value, last, status, message_length,
    input  ready
  );
  modport sink (
    input  valid, byte_offset, byte_value, last, status, message_length,
    output ready
  );
endinterface

// ===== rtl/dqe_track.sv =====
module dqe_track (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  dqe_pkg::dqe_item_t item_i,
  input  logic              job_pop_i,
  output logic              job_valid_o,
  output dqe_pkg::dqe_job_t job_o
);
  import dqe_pkg::*;

  logic [8:0]  wo_q, wo_d;
  logic [8:0]  ls_q, ls_d;
  logic [6:0]  lc_q, lc_d;
  logic [8:0]  nb_q, nb_d;
  logic [15:0] type_q, type_d;
  logic        disc_q, disc_d;
  logic        act_q, act_d;
  logic        job_valid_q, job_valid_d;
  dqe_job_t    job_q, job_d;

  logic [8:0]  eff_wo, eff_ls, eff_nb;
  logic [6:0]  eff_lc;
  logic [15:0] eff_type;
  logic        eff_disc, eff_act;
  logic        accept;
  logic [4:0]  body_cnt;

  assign in_ready_o = !job_valid_q || job_pop_i;
  assign accept     = in_valid_i && in_ready_o;

  // context seen by this item: a first item opens a fresh query
  always_comb begin
    if (item_i.first) begin
      eff_wo   = 9'(HdrLen + 1);
      eff_ls   = 9'(HdrLen);
      eff_lc   = '0;
      eff_nb   = 9'(MaxName - 1);
      eff_type = item_i.query_type;
      eff_disc = 1'b0;
      eff_act  = 1'b1;
    end else begin
      eff_wo   = wo_q;
      eff_ls   = ls_q;
      eff_lc   = lc_q;
      eff_nb   = nb_q;
      eff_type = type_q;
      eff_disc = disc_q;
      eff_act  = act_q;
    end
  end

  // state update and job decode
  always_comb begin
    wo_d   = wo_q;
    ls_d   = ls_q;
    lc_d   = lc_q;
    nb_d   = nb_q;
    type_d = type_q;
    disc_d = disc_q;
    act_d  = act_q;

    job_d       = job_q;
    job_d.hdr   = item_i.first;
    job_d.xid   = item_i.xid;
    job_d.rd    = item_i.recursion_desired;
    job_d.kind  = KIND_NONE;
    job_d.ofs   = '0;
    job_d.val   = '0;
    job_d.wofs  = eff_wo;
    job_d.qtype = eff_type;

    if (accept && eff_act) begin
      wo_d   = eff_wo;
      ls_d   = eff_ls;
      lc_d   = eff_lc;
      nb_d   = eff_nb;
      type_d = eff_type;
      disc_d = eff_disc;
      act_d  = eff_act;
      if (eff_disc) begin
        if (item_i.name_char == CharEnd) begin
          disc_d = 1'b0;
          act_d  = 1'b0;
        end
      end else if (item_i.name_char == CharDot) begin
        if (eff_nb == '0) begin
          disc_d     = 1'b1;
          job_d.kind = KIND_FAIL;
        end else begin
          job_d.kind = KIND_PATCH;
          job_d.ofs  = eff_ls;
          job_d.val  = {1'b0, eff_lc};
          ls_d       = eff_wo;
          wo_d       = eff_wo + 9'd1;
          nb_d       = eff_nb - 9'd1;
          lc_d       = '0;
        end
      end else if (item_i.name_char == CharEnd) begin
        job_d.kind = KIND_TERM;
        job_d.ofs  = eff_ls;
        job_d.val  = {1'b0, eff_lc};
        wo_d       = eff_wo + 9'(TermResults - 1);
        act_d      = 1'b0;
      end else if (eff_lc >= 7'(MaxLabel) || eff_nb <= 9'd1) begin
        disc_d     = 1'b1;
        job_d.kind = KIND_FAIL;
      end else begin
        job_d.kind = KIND_CHAR;
        job_d.ofs  = eff_wo;
        job_d.val  = item_i.name_char;
        lc_d       = eff_lc + 7'd1;
        nb_d       = eff_nb - 9'd1;
        wo_d       = eff_wo + 9'd1;
      end
    end

    // result count of this item
    case (job_d.kind)
      KIND_CHAR, KIND_PATCH, KIND_FAIL: body_cnt = 5'd1;
      KIND_TERM:                        body_cnt = 5'(TermResults);
      default:                          body_cnt = 5'd0;
    endcase
    job_d.cnt = body_cnt + (item_i.first ? 5'(HdrLen) : 5'd0);

    if (accept) begin
      job_valid_d = (job_d.cnt != 5'd0);
    end else if (job_pop_i) begin
      job_valid_d = 1'b0;
    end else begin
      job_valid_d = job_valid_q;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wo_q        <= 9'(HdrLen);
      ls_q        <= 9'(HdrLen);
      lc_q        <= '0;
      nb_q        <= 9'(MaxName);
      type_q      <= '0;
      disc_q      <= 1'b0;
      act_q       <= 1'b0;
      job_valid_q <= 1'b0;
    end else begin
      wo_q        <= wo_d;
      ls_q        <= ls_d;
      lc_q        <= lc_d;
      nb_q        <= nb_d;
      type_q      <= type_d;
      disc_q      <= disc_d;
      act_q       <= act_d;
      job_valid_q <= job_valid_d;
    end
  end

  // job payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      job_q <= job_d;
    end
  end

  assign job_valid_o = job_valid_q;
  assign job_o       = job_q;

endmodule

// ===== rtl/dqe_emit.sv =====
module dqe_emit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                job_valid_i,
  input  dqe_pkg::dqe_job_t   job_i,
  output logic                job_pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output dqe_pkg::dqe_result_t out_o
);
  import dqe_pkg::*;

  logic [4:0]  idx_q, idx_d;
  logic        out_valid_q, out_valid_d;
  dqe_result_t out_q, res;
  logic        out_load, fire, job_end;
  logic [4:0]  body_j;

  assign out_load  = !out_valid_q || out_ready_i;
  assign fire      = out_load && job_valid_i;
  assign job_end   = (idx_q == job_i.cnt - 5'd1);
  assign job_pop_o = fire && job_end;
  assign body_j    = job_i.hdr ? idx_q - 5'(HdrLen) : idx_q;

  // byte selected by the current index
  always_comb begin
    res = '0;
    if (job_i.hdr && idx_q < 5'(HdrLen)) begin
      res.byte_offset = {4'd0, idx_q};
      case (idx_q[3:0])
        4'd0:    res.byte_value = job_i.xid[7:0];
        4'd1:    res.byte_value = job_i.xid[15:8];
        4'd2:    res.byte_value = {7'd0, job_i.rd};
        4'd4:    res.byte_value = QcountOne[7:0];
        4'd5:    res.byte_value = QcountOne[15:8];
        default: res.byte_value = 8'd0;
      endcase
    end else begin
      case (job_i.kind)
        KIND_CHAR, KIND_PATCH: begin
          res.byte_offset = job_i.ofs;
          res.byte_value  = job_i.val;
        end
        KIND_FAIL: begin
          res.last   = 1'b1;
          res.status = 1'b1;
        end
        KIND_TERM: begin
          // label patch, root zero, type and class
          case (body_j[2:0])
            3'd0: begin
              res.byte_offset = job_i.ofs;
              res.byte_value  = job_i.val;
            end
            3'd1: begin
              res.byte_offset = job_i.wofs;
            end
            3'd2: begin
              res.byte_offset = job_i.wofs + 9'd1;
              res.byte_value  = job_i.qtype[7:0];
            end
            3'd3: begin
              res.byte_offset = job_i.wofs + 9'd2;
              res.byte_value  = job_i.qtype[15:8];
            end
            3'd4: begin
              res.byte_offset = job_i.wofs + 9'd3;
              res.byte_value  = ClassIn[7:0];
            end
            3'd5: begin
              res.byte_offset    = job_i.wofs + 9'd4;
              res.byte_value     = ClassIn[15:8];
              res.last           = 1'b1;
              res.message_length = job_i.wofs + 9'd5;
            end
            default: res = '0;
          endcase
        end
        default: res = '0;
      endcase
    end
  end

  // index and output register control
  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
      idx_d       = job_end ? 5'd0 : idx_q + 5'd1;
    end else if (out_load) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// ===== rtl/dns_question_encoder.sv =====
// DNS query encoder: turns a dotted name, one character per transaction on
// item_i, into the bytes of a query message, one byte per transaction on
// result_o together with its offset in the message.
// An item with first set starts a new query and yields the 12 header bytes
// ahead of its own character. A plain character yields one byte, a dot
// yields the length patch of the closed label, the zero terminator yields
// six bytes (patch, root zero, type, class) with last set and the message
// length. A bad name yields one result with status set; later items up to
// the terminator give nothing.
// An item passes the decode register, then the output register, on its way
// to result_o. Throughput: one item per cycle while each item yields at most
// one byte and result_o does not stall; an item with n results holds the
// output channel until its n results have left, and the decode register takes
// the next item in the cycle its last byte leaves.
// Reset clears the name context to idle; items other than first are ignored
// until a query opens. When result_o stalls, the output holds and item_i
// drops ready once the decode register is full.
module dns_question_encoder (
  input  logic         clk_i,
  input  logic         rst_ni,
  dqe_item_if.sink     item_i,
  dqe_result_if.source result_o
);
  import dqe_pkg::*;

  dqe_item_t   item;
  dqe_job_t    job;
  dqe_result_t res;
  logic        in_ready, job_valid, job_pop, out_valid;

  assign item.name_char         = item_i.name_char;
  assign item.first             = item_i.first;
  assign item.xid               = item_i.xid;
  assign item.query_type        = item_i.query_type;
  assign item.recursion_desired = item_i.recursion_desired;
  assign item_i.ready           = in_ready;

  // name context and decode register
  dqe_track u_track (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (item_i.valid),
    .in_ready_o  (in_ready),
    .item_i      (item),
    .job_pop_i   (job_pop),
    .job_valid_o (job_valid),
    .job_o       (job)
  );

  // byte serializer and output register
  dqe_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (job),
    .job_pop_o   (job_pop),
    .out_valid_o (out_valid),
    .out_ready_i (result_o.ready),
    .out_o       (res)
  );

  assign result_o.valid          = out_valid;
  assign result_o.byte_offset    = res.byte_offset;
  assign result_o.byte_value     = res.byte_value;
  assign result_o.last           = res.last;
  assign result_o.status         = res.status;
  assign result_o.message_length = res.message_length;

endmodule

// ===== rtl/dqe_checker.sv =====
module dqe_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [8:0] byte_offset_i,
  input logic [7:0] byte_value_i,
  input logic       last_i,
  input logic       status_i,
  input logic [8:0] message_length_i
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(byte_offset_i)
      && $stable(byte_value_i) && $stable(last_i) && $stable(status_i)
      && $stable(message_length_i))
    else $error("result changed while stalled");

  // an error result is a bare marker that ends the query
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i |-> last_i && byte_offset_i == 9'd0
      && byte_value_i == 8'd0 && message_length_i == 9'd0)
    else $error("malformed error result");

  // the final class byte sits right before the message end
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && last_i && !status_i |->
      message_length_i == byte_offset_i + 9'd1 && byte_value_i == 8'h01)
    else $error("message length does not match last byte");

  // length is reported only on the final byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !last_i |-> message_length_i == 9'd0 && !status_i)
    else $error("length or status on a non-final byte");

endmodule

bind dns_question_encoder dqe_checker u_dqe_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (result_o.valid),
  .out_ready_i      (result_o.ready),
  .byte_offset_i    (result_o.byte_offset),
  .byte_value_i     (result_o.byte_value),
  .last_i           (result_o.last),
  .status_i         (result_o.status),
  .message_length_i (result_o.message_length)
);
